// ===== rtl/tape_block_pulse_generator_macros.svh =====
// Assertion macros for the tape block pulse generator checker.
// No dependencies.
`ifndef TAPE_BLOCK_PULSE_GENERATOR_MACROS_SVH
`define TAPE_BLOCK_PULSE_GENERATOR_MACROS_SVH
// implication checked on every clock, held off during reset
`define TBPG_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("tbpg check failed");
// next-cycle implication
`define TBPG_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("tbpg check failed");
`endif

// ===== rtl/tbpg_pkg.sv =====
// Shared types, codes and helpers of the tape block pulse generator.
// No dependencies.
package tbpg_pkg;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [1:0] {OP_START = 2'd0, OP_EXPIRY = 2'd1, OP_STOP = 2'd2,
                            OP_NONE = 2'd3} op_t;
  typedef enum logic [3:0] {PH_IDLE, PH_PILOT_LOW, PH_PILOT_HIGH, PH_SYNC_LOW,
                            PH_SYNC_HIGH, PH_DATA_LOW, PH_DATA_HIGH, PH_TERM,
                            PH_GAP} phase_t;
  typedef enum logic [2:0] {ST_STOPPED = 3'd0, ST_RUNNING = 3'd1, ST_FINISHED = 3'd2,
                            ST_UNDERRUN = 3'd3, ST_BADFILE = 3'd4} status_t;
  typedef enum logic [2:0] {CFG_PILOT = 3'd0, CFG_SYNC_LO = 3'd1, CFG_SYNC_HI = 3'd2,
                            CFG_LONG = 3'd3, CFG_SHORT = 3'd4} cfg_idx_t;

  localparam logic [11:0] HEADER_PILOTS = 12'd4032;
  localparam logic [11:0] DATA_PILOTS = 12'd1610;
  localparam logic [15:0] CHUNK_TICKS = 16'd60000;
  localparam logic [8:0] HEADER_CHUNKS = 9'd93;
  localparam logic [8:0] DATA_CHUNKS = 9'd266;
  localparam logic [15:0] HEADER_TAIL = 16'd20000;
  localparam logic [15:0] DATA_TAIL = 16'd40000;

  // item after classification in the front end
  typedef struct packed {
    op_t         op;
    logic [15:0] block_length;
    logic [7:0]  block_flag;
    logic        block_is_last;
    logic        block_ready;
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        source_finished;
  } item_t;

  typedef struct packed {
    logic        line_level;
    logic        interval_valid;
    logic [15:0] interval_ticks;
    logic        byte_taken;
    logic        block_taken;
    logic        need_block;
    logic        tape_activity;
    logic [2:0]  status;
    logic [15:0] progress_added;
    logic [31:0] progress_elapsed;
  } result_t;

  // ceil(ticks/256), zero forced to one; input up to 17 bits
  function automatic logic [15:0] units_of(input logic [16:0] ticks);
    logic [17:0] u;
    u = ({1'b0, ticks} + 18'd255) >> 8;
    if (u == 18'd0) return 16'd1;
    return u[15:0];
  endfunction
endpackage

// ===== rtl/tbpg_front.sv =====
// Front end: two-entry input queue and op classification.
// Depends on tbpg_pkg.
module tbpg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_block_length,
  input  logic [7:0]          in_block_flag,
  input  logic                in_block_is_last,
  input  logic                in_block_ready,
  input  logic                in_byte_valid,
  input  logic [7:0]          in_byte_value,
  input  logic                in_source_finished,
  output logic                q_valid,
  output tbpg_pkg::item_t     q_item,
  input  logic                q_take
);
  import tbpg_pkg::*;
  item_t  mem_r [QDEPTH];
  logic   wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push_ok;
  item_t  it;

  always_comb begin
    it.op = op_t'(in_op);
    it.block_length = in_block_length;
    it.block_flag = in_block_flag;
    it.block_is_last = in_block_is_last;
    it.block_ready = in_block_ready;
    it.byte_valid = in_byte_valid;
    it.byte_value = in_byte_value;
    it.source_finished = in_source_finished;
  end

  assign in_full = (cnt_r == 2'(QDEPTH));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push_ok) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(q_take);
    end
  end
endmodule

// ===== rtl/tbpg_back.sv =====
// Back end: phase sequencer, progress count and result register.
// Depends on tbpg_pkg.
module tbpg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tbpg_pkg::item_t     q_item,
  output logic                q_take,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                res_valid,
  output tbpg_pkg::result_t   res,
  input  logic                res_pop
);
  import tbpg_pkg::*;
  logic [15:0] pilot_r, synclo_r, synchi_r, long_r, short_r;
  phase_t  phase_r, phase_nxt;
  status_t st_r, st_nxt;
  logic [15:0] len_r, len_nxt, sent_r, sent_nxt, bht_r, bht_nxt;
  logic [15:0] tail_r, tail_nxt, gpu_r, gpu_nxt;
  logic        hdr_r, hdr_nxt, fin_r, fin_nxt, wants_r, wants_nxt;
  logic [7:0]  sb_r, sb_nxt, bsel_r, bsel_nxt;
  logic [11:0] pil_r, pil_nxt;
  logic [8:0]  chunks_r, chunks_nxt;
  logic [31:0] el_r, el_nxt;
  logic        rv_r;
  result_t     res_r, res_nxt;
  logic        iv, btk, ktk;
  logic [15:0] ticks, added;
  logic [32:0] sum;
  logic [7:0]  shifted;
  item_t       i;

  assign cfg_ready = 1'b1;
  assign q_take = q_valid && (!rv_r || res_pop);
  assign res_valid = rv_r;
  assign res = res_r;
  assign i = q_item;

  always_comb begin
    phase_nxt = phase_r; st_nxt = st_r; len_nxt = len_r; sent_nxt = sent_r;
    bht_nxt = bht_r; tail_nxt = tail_r; gpu_nxt = gpu_r; hdr_nxt = hdr_r;
    fin_nxt = fin_r; wants_nxt = wants_r; sb_nxt = sb_r; bsel_nxt = bsel_r;
    pil_nxt = pil_r; chunks_nxt = chunks_r; el_nxt = el_r;
    iv = 1'b0; btk = 1'b0; ktk = 1'b0; ticks = 16'd0; added = 16'd0;
    sum = 33'd0;
    shifted = bsel_r >> 1;
    case (i.op)
      OP_START, OP_STOP: begin
        phase_nxt = PH_IDLE; st_nxt = ST_STOPPED; len_nxt = 16'd0; sent_nxt = 16'd0;
        hdr_nxt = 1'b1; fin_nxt = 1'b1; sb_nxt = 8'd0; bsel_nxt = 8'h80;
        bht_nxt = 16'd1; pil_nxt = 12'd0; chunks_nxt = 9'd0; tail_nxt = 16'd0;
        gpu_nxt = 16'd0; el_nxt = 32'd0; wants_nxt = 1'b0;
        if (i.op == OP_START) begin
          len_nxt = i.block_length; hdr_nxt = (i.block_flag == 8'h00);
          fin_nxt = i.block_is_last; sb_nxt = i.block_flag;
          pil_nxt = (i.block_flag == 8'h00) ? HEADER_PILOTS : DATA_PILOTS;
          st_nxt = ST_RUNNING; phase_nxt = PH_PILOT_LOW; ktk = 1'b1;
          iv = 1'b1; ticks = pilot_r;
        end
      end
      OP_EXPIRY: begin
        if (st_r == ST_RUNNING) begin
          iv = 1'b1;
          unique case (phase_r)
            PH_PILOT_LOW: begin phase_nxt = PH_PILOT_HIGH; ticks = pilot_r; end
            PH_PILOT_HIGH: begin
              added = units_of({pilot_r, 1'b0});
              if (pil_r > 12'd1) begin
                pil_nxt = pil_r - 12'd1; phase_nxt = PH_PILOT_LOW; ticks = pilot_r;
              end else begin
                pil_nxt = 12'd0; phase_nxt = PH_SYNC_LOW; ticks = synclo_r;
              end
            end
            PH_SYNC_LOW: begin phase_nxt = PH_SYNC_HIGH; ticks = synchi_r; end
            PH_SYNC_HIGH: begin
              added = units_of({1'b0, synclo_r} + {1'b0, synchi_r});
              bht_nxt = ((sb_r & bsel_r) != 8'd0) ? long_r : short_r;
              phase_nxt = PH_DATA_LOW; ticks = bht_nxt;
            end
            PH_DATA_LOW: begin phase_nxt = PH_DATA_HIGH; ticks = bht_r; end
            PH_DATA_HIGH: begin
              added = units_of({1'b0, long_r} + {1'b0, short_r});
              bsel_nxt = shifted;
              phase_nxt = PH_DATA_LOW;
              if (shifted == 8'd0) begin
                sent_nxt = sent_r + 16'd1;
                if (sent_nxt >= len_r) begin
                  phase_nxt = PH_TERM; ticks = pilot_r;
                end else if (!i.byte_valid) begin
                  st_nxt = i.source_finished ? ST_BADFILE : ST_UNDERRUN;
                  phase_nxt = PH_IDLE; iv = 1'b0;
                end else begin
                  btk = 1'b1; sb_nxt = i.byte_value; bsel_nxt = 8'h80;
                end
              end
              if (phase_nxt == PH_DATA_LOW) begin
                bht_nxt = ((sb_nxt & bsel_nxt) != 8'd0) ? long_r : short_r;
                ticks = bht_nxt;
              end
            end
            PH_TERM: begin
              added = units_of({1'b0, pilot_r});
              if (fin_r) begin
                phase_nxt = PH_IDLE; st_nxt = ST_FINISHED; iv = 1'b0;
              end else begin
                // first gap piece is always a full chunk
                wants_nxt = 1'b1; phase_nxt = PH_GAP;
                chunks_nxt = (hdr_r ? HEADER_CHUNKS : DATA_CHUNKS) - 9'd1;
                tail_nxt = hdr_r ? HEADER_TAIL : DATA_TAIL;
                gpu_nxt = units_of({1'b0, CHUNK_TICKS}); ticks = CHUNK_TICKS;
              end
            end
            PH_GAP: begin
              added = gpu_r;
              if (chunks_r != 9'd0) begin
                chunks_nxt = chunks_r - 9'd1;
                gpu_nxt = units_of({1'b0, CHUNK_TICKS}); ticks = CHUNK_TICKS;
              end else if (tail_r != 16'd0) begin
                ticks = tail_r; gpu_nxt = units_of({1'b0, tail_r}); tail_nxt = 16'd0;
              end else begin
                gpu_nxt = 16'd0;
                if (!i.block_ready) begin
                  st_nxt = ST_UNDERRUN; phase_nxt = PH_IDLE; iv = 1'b0;
                end else begin
                  len_nxt = i.block_length; sent_nxt = 16'd0;
                  hdr_nxt = (i.block_flag == 8'h00); fin_nxt = i.block_is_last;
                  sb_nxt = i.block_flag; bsel_nxt = 8'h80; bht_nxt = 16'd1;
                  pil_nxt = (i.block_flag == 8'h00) ? HEADER_PILOTS : DATA_PILOTS;
                  ktk = 1'b1; wants_nxt = 1'b0;
                  phase_nxt = PH_PILOT_LOW; ticks = pilot_r;
                end
              end
            end
            default: begin st_nxt = ST_BADFILE; phase_nxt = PH_IDLE; iv = 1'b0; end
          endcase
          sum = {1'b0, el_r} + {17'd0, added};
          el_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      default: ;
    endcase
    if (!iv) ticks = 16'd0;
    else if (ticks == 16'd0) ticks = 16'd1;
    res_nxt.line_level = (phase_nxt == PH_PILOT_HIGH) || (phase_nxt == PH_SYNC_HIGH) ||
                         (phase_nxt == PH_DATA_HIGH);
    res_nxt.interval_valid = iv;
    res_nxt.interval_ticks = ticks;
    res_nxt.byte_taken = btk;
    res_nxt.block_taken = ktk;
    res_nxt.need_block = wants_nxt;
    res_nxt.tape_activity = (st_nxt == ST_RUNNING) && (phase_nxt != PH_GAP) &&
                            (phase_nxt != PH_IDLE);
    res_nxt.status = st_nxt;
    res_nxt.progress_added = added;
    res_nxt.progress_elapsed = el_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_take) res_r <= res_nxt;
    if (!rst_n) begin
      pilot_r <= 16'd2168; synclo_r <= 16'd667; synchi_r <= 16'd735;
      long_r <= 16'd1710; short_r <= 16'd855;
      phase_r <= PH_IDLE; st_r <= ST_STOPPED; len_r <= 16'd0; sent_r <= 16'd0;
      hdr_r <= 1'b1; fin_r <= 1'b1; sb_r <= 8'd0; bsel_r <= 8'h80; bht_r <= 16'd1;
      pil_r <= 12'd0; chunks_r <= 9'd0; tail_r <= 16'd0; gpu_r <= 16'd0;
      el_r <= 32'd0; wants_r <= 1'b0; rv_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PILOT:   pilot_r <= cfg_data;
          CFG_SYNC_LO: synclo_r <= cfg_data;
          CFG_SYNC_HI: synchi_r <= cfg_data;
          CFG_LONG:    long_r <= cfg_data;
          CFG_SHORT:   short_r <= cfg_data;
          default: ;
        endcase
      end
      if (q_take) begin
        phase_r <= phase_nxt; st_r <= st_nxt; len_r <= len_nxt; sent_r <= sent_nxt;
        hdr_r <= hdr_nxt; fin_r <= fin_nxt; sb_r <= sb_nxt; bsel_r <= bsel_nxt;
        bht_r <= bht_nxt; pil_r <= pil_nxt; chunks_r <= chunks_nxt;
        tail_r <= tail_nxt; gpu_r <= gpu_nxt; el_r <= el_nxt; wants_r <= wants_nxt;
      end
      if (q_take) rv_r <= 1'b1;
      else if (res_pop) rv_r <= 1'b0;
    end
  end
endmodule

// ===== rtl/tape_block_pulse_generator.sv =====
// Top level of the tape block pulse generator.
// Depends on tbpg_pkg, tbpg_front and tbpg_back.
//
// Input channel: push an item (start, timer expiry or stop with the offered
// block and byte fields) while full is low. Each item yields one result word
// on the out_ ports, shown while empty is low and removed by pop.
// A two-entry queue in the front end holds items; the back end runs the
// phase sequencer and updates one phase per item.
// An accepted item is written to a queue entry and then, once the result
// register is free or being popped, into the result register on the out_ ports.
// Throughput: one item per cycle while the receiver keeps popping; the
// result register is refilled in the cycle it is popped.
// When the receiver stalls the result holds, the queue fills and full rises.
// Configuration: cfg_valid with cfg_index (0 pilot, 1 sync low, 2 sync high,
// 3 long, 4 short) and cfg_data; cfg_ready is always high.
// Reset (synchronous, rst_n low) empties the queue, stops the tape, and
// returns the timing registers to their defaults.
module tape_block_pulse_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_block_length,
  input  logic [7:0]  in_block_flag,
  input  logic        in_block_is_last,
  input  logic        in_block_ready,
  input  logic        in_byte_valid,
  input  logic [7:0]  in_byte_value,
  input  logic        in_source_finished,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_line_level,
  output logic        out_interval_valid,
  output logic [15:0] out_interval_ticks,
  output logic        out_byte_taken,
  output logic        out_block_taken,
  output logic        out_need_block,
  output logic        out_tape_activity,
  output logic [2:0]  out_status,
  output logic [15:0] out_progress_added,
  output logic [31:0] out_progress_elapsed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tbpg_pkg::*;
  logic    q_valid, q_take, res_valid;
  item_t   q_item;
  result_t res;

  tbpg_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_op, .in_block_length, .in_block_flag,
    .in_block_is_last, .in_block_ready, .in_byte_valid, .in_byte_value,
    .in_source_finished, .q_valid, .q_item, .q_take
  );

  tbpg_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_take, .cfg_valid, .cfg_ready, .cfg_index,
    .cfg_data, .res_valid, .res, .res_pop(out_pop)
  );

  assign out_empty = !res_valid;
  assign out_line_level = res.line_level;
  assign out_interval_valid = res.interval_valid;
  assign out_interval_ticks = res.interval_ticks;
  assign out_byte_taken = res.byte_taken;
  assign out_block_taken = res.block_taken;
  assign out_need_block = res.need_block;
  assign out_tape_activity = res.tape_activity;
  assign out_status = res.status;
  assign out_progress_added = res.progress_added;
  assign out_progress_elapsed = res.progress_elapsed;
endmodule

// ===== rtl/tbpg_checker.sv =====
// Port-level checker for the tape block pulse generator, bound to the top.
// Depends on tbpg_pkg and tape_block_pulse_generator_macros.svh.
`include "tape_block_pulse_generator_macros.svh"
module tbpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_interval_valid,
  input logic [15:0] out_interval_ticks,
  input logic        out_tape_activity,
  input logic [2:0]  out_status,
  input logic        out_block_taken,
  input logic [31:0] out_progress_elapsed
);
  import tbpg_pkg::*;
  `TBPG_ASSERT_IMP(a_iv_ticks, clk, rst_n, !out_empty,
    out_interval_valid == (out_interval_ticks != 16'd0))
  `TBPG_ASSERT_IMP(a_act_run, clk, rst_n, !out_empty && out_tape_activity,
    out_status == ST_RUNNING)
  `TBPG_ASSERT_IMP(a_take_run, clk, rst_n, !out_empty && out_block_taken,
    out_status == ST_RUNNING && out_interval_valid)
  `TBPG_ASSERT_NXT(a_hold, clk, rst_n, !out_empty && !out_pop,
    !out_empty && $stable(out_progress_elapsed))
endmodule

bind tape_block_pulse_generator tbpg_checker u_checker (.*);
